// File: design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define AST_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define AST_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// File: design/mmix_pkg.sv
`default_nettype none
package mmix_pkg;
    localparam int MaxMotors = 8;
    localparam int FracBits  = 12;
    localparam int CoefBits  = 14;
    localparam int MotW      = $clog2(MaxMotors);
    localparam logic [12:0] OneLevel = 13'(1 << FracBits);
    localparam logic signed [23:0] SatMax = 24'sh7FFFFF;
    localparam logic signed [23:0] SatMin = -24'sh800000;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_UNSET = 2'd1, ST_CHAN = 2'd2, ST_BOUNDS = 2'd3
    } t_status;

    localparam logic [1:0] ACT_MIX    = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_SAT    = 2'd2;
    localparam logic [1:0] ACT_IGNORE = 2'd3;

    function automatic logic signed [15:0] coef(input logic [2:0] lay,
                                                 input logic [2:0] row,
                                                 input logic [2:0] col);
        logic signed [15:0] t [0:5][0:7][0:5];
        t = '{
          '{'{0,0,-16384,-8192, 8192, 8192},'{0,0,-16384,-8192,-8192,-8192},
            '{0,0,-16384, 8192,-8192, 8192},'{0,0,-16384, 8192, 8192,-8192},
            '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
          '{'{0,0,-16384,0,8192,8192},'{0,0,-16384,-8192,0,-8192},
            '{0,0,-16384,0,-8192,8192},'{0,0,-16384,8192,0,-8192},
            '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
          '{'{0,0,-16384,-4096,8192,8192},'{0,0,-16384,-8192,0,-8192},
            '{0,0,-16384,-4096,-8192,8192},'{0,0,-16384,4096,-8192,-8192},
            '{0,0,-16384,8192,0,8192},'{0,0,-16384,4096,8192,-8192},
            '{0,0,0,0,0,0},'{0,0,0,0,0,0}},
          '{'{0,0,-16384,-3441,8192,8192},'{0,0,-16384,-8192,3441,-8192},
            '{0,0,-16384,-8192,-3441,8192},'{0,0,-16384,-3441,-8192,-8192},
            '{0,0,-16384,3441,-8192,8192},'{0,0,-16384,8192,-3441,-8192},
            '{0,0,-16384,8192,3441,8192},'{0,0,-16384,3441,8192,-8192}},
          '{'{-4483,5960,-16384,-3757,6424,5641},'{10424,305,-16384,-5960,-487,-5960},
            '{-5541,-5788,-16384,-5439,-5960,5810},'{-5541,5788,-16384,5439,-5960,-5810},
            '{10424,-305,-16384,5960,-487,5960},'{-4483,-5960,-16384,3757,6424,-5641},
            '{0,0,0,0,0,0},'{0,0,0,0,0,0}},
          '{'{-3762,3762,-16384,-3750,3762,3639},'{7769,0,-16384,-3762,0,-3762},
            '{-3762,-3762,-16384,-3750,-3762,3639},'{-3762,3762,-16384,3750,-3762,-3639},
            '{7769,0,-16384,3762,0,3762},'{-3762,-3762,-16384,3750,3762,-3639},
            '{0,0,0,0,0,0},'{0,0,0,0,0,0}}};
        if (lay > 3'd5 || col > 3'd5) begin
            coef = '0;
        end else begin
            coef = t[lay][row][col];
        end
    endfunction

    function automatic logic [3:0] rotors(input logic [2:0] lay);
        logic [3:0] n;
        case (lay)
            3'd2, 3'd4, 3'd5: n = 4'd6;
            3'd3:             n = 4'd8;
            default:          n = 4'd4;
        endcase
        rotors = (n > 4'(MaxMotors)) ? 4'(MaxMotors) : n;
    endfunction
endpackage
`default_nettype wire

// File: design/multirotor_motor_mixer.sv
// channel | dir | handshake          | payload
// in      | in  | i_valid / o_stall  | action, channel, amount, six controls
// out     | out | o_valid / i_stall  | status, index, level, range, last
// cfg     | in  | i_cfg_we           | i_cfg_data (layout)
// Mix: six multiplies per motor, one per control, through one 16x16 multiplier.
// Add: each motor's level gains amount times its channel coefficient. Check: per
//   motor two 40-bit restoring divides (setup, 40 steps, update), skipped at zero coef.
// Mix and add stream one beat per motor, check one range beat; emit waits on i_stall.
// Input is stalled whenever an item is in flight. Synchronous active-low reset
// clears levels and sets layout unset.
`default_nettype none
module multirotor_motor_mixer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [2:0]  i_channel,
    input  wire logic signed [15:0] i_amount,
    input  wire logic signed [15:0] i_ctrl_x,
    input  wire logic signed [15:0] i_ctrl_y,
    input  wire logic signed [15:0] i_ctrl_z,
    input  wire logic signed [15:0] i_ctrl_roll,
    input  wire logic signed [15:0] i_ctrl_pitch,
    input  wire logic signed [15:0] i_ctrl_yaw,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [2:0]       o_motor_index,
    output logic [12:0]      o_motor_level,
    output logic signed [23:0] o_range_min,
    output logic signed [23:0] o_range_max,
    output logic             o_last
);
    import mmix_pkg::*;
`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_ADD, S_DIVSET, S_DIV, S_DIVEND, S_EMIT, S_SATOUT
    } t_state;

    t_state r_state;
    logic [2:0] r_layout;
    logic [12:0] r_lvl [0:MaxMotors-1];
    logic [1:0] r_act;
    logic [2:0] r_ch;
    logic signed [15:0] r_amt;
    logic signed [15:0] r_u [0:5];
    logic [MotW:0] r_mot;
    logic [2:0] r_col;
    logic signed [38:0] r_acc;
    logic signed [23:0] r_lo, r_hi;
    logic r_which;   // 0: up bound, 1: down bound
    // divider
    logic [39:0] r_quo;
    logic [40:0] r_rem;
    logic [14:0] r_den;
    logic r_neg;
    logic [5:0] r_dcnt;

    logic [3:0] nmot;
    logic signed [15:0] mul_a, cf;
    logic signed [31:0] prod;
    logic signed [39:0] rnd;
    logic [MotW-1:0] mi;
    logic signed [15:0] cc;
    logic signed [23:0] qs;
    logic [40:0] trial;
    logic signed [39:0] num;
    logic signed [40:0] qext;

    assign nmot = rotors(r_layout);
    assign mi = r_mot[MotW-1:0];
    assign o_stall = (r_state != S_IDLE) || o_valid;
    assign cf = coef(r_layout, 3'(mi), (r_act == ACT_MIX) ? r_col : r_ch);
    assign mul_a = (r_act == ACT_MIX) ? r_u[r_col] : r_amt;
    assign prod = mul_a * cf;

    // floor((v + 2^13) / 2^14); arithmetic shift is floor
    function automatic logic signed [39:0] rshift(input logic signed [39:0] v);
        logic signed [39:0] w;
        w = v + 40'sd8192;
        rshift = w >>> CoefBits;
    endfunction

    function automatic logic [12:0] clampl(input logic signed [39:0] v);
        if (v > $signed({27'd0, OneLevel})) clampl = OneLevel;
        else if (v < 0) clampl = '0;
        else clampl = v[12:0];
    endfunction

    assign rnd = (r_state == S_ADD)
        ? rshift(40'(prod)) + 40'($signed({1'b0, r_lvl[mi]}))
        : rshift(40'(r_acc));
    assign cc = cf;
    // numerator: (1-m)*2^14 or -m*2^14, chosen per sign of c
    assign num = ((r_which == 1'b0) == (cc > 0))
        ? 40'(($signed({1'b0, OneLevel}) - $signed({1'b0, r_lvl[mi]})) * 32768 / 2)
        : 40'(-($signed({1'b0, r_lvl[mi]})) * 16384);
    assign trial = {r_rem[39:0], r_quo[39]} - {26'd0, r_den};
    assign qext = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign qs = (qext > 41'(SatMax)) ? SatMax :
                (qext < 41'(SatMin)) ? SatMin : qext[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_layout <= 3'd6;
            o_valid <= 1'b0;
            for (int k = 0; k < MaxMotors; k++) r_lvl[k] <= '0;
        end else begin
            if (i_cfg_we) r_layout <= i_cfg_data;
            // the emit state drives o_valid itself
            if (o_valid && !i_stall && r_state != S_EMIT) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && !o_stall) begin
                    r_act <= i_action; r_ch <= i_channel; r_amt <= i_amount;
                    r_u[0] <= i_ctrl_x; r_u[1] <= i_ctrl_y; r_u[2] <= i_ctrl_z;
                    r_u[3] <= i_ctrl_roll; r_u[4] <= i_ctrl_pitch; r_u[5] <= i_ctrl_yaw;
                    r_mot <= '0; r_col <= '0; r_acc <= '0;
                    r_lo <= SatMin; r_hi <= SatMax; r_which <= 1'b0;
                    o_status <= ST_OK; o_motor_index <= '0; o_motor_level <= '0;
                    o_range_min <= '0; o_range_max <= '0; o_last <= 1'b1;
                    if (i_action == ACT_IGNORE) begin
                        r_state <= S_IDLE;
                    end else if (r_layout > 3'd5) begin
                        o_status <= ST_UNSET; o_valid <= 1'b1;
                    end else if (i_action != ACT_MIX && (i_channel > 3'd5 ||
                               (r_layout < 3'd4 && i_channel < 3'd2))) begin
                        o_status <= ST_CHAN; o_valid <= 1'b1;
                    end else begin
                        r_state <= (i_action == ACT_MIX) ? S_MAC :
                                   (i_action == ACT_ADD) ? S_ADD : S_DIVSET;
                    end
                end
                S_MAC: begin
                    if (r_col == 3'd5) begin
                        r_acc <= '0; r_col <= '0;
                        r_lvl[mi] <= clampl(rshift(40'(r_acc + 39'(prod))));
                        if (r_mot + 1'b1 == {1'b0, nmot}) begin
                            r_mot <= '0; r_state <= S_EMIT;
                        end else r_mot <= r_mot + 1'b1;
                    end else begin
                        r_acc <= r_acc + 39'(prod);
                        r_col <= r_col + 3'd1;
                    end
                end
                S_ADD: begin
                    r_lvl[mi] <= clampl(rnd);
                    if (r_mot + 1'b1 == {1'b0, nmot}) begin
                        r_mot <= '0; r_state <= S_EMIT;
                    end else r_mot <= r_mot + 1'b1;
                end
                S_EMIT: if (!o_valid || !i_stall) begin
                    o_valid <= 1'b1; o_status <= ST_OK;
                    o_motor_index <= 3'(mi); o_motor_level <= r_lvl[mi];
                    o_range_min <= '0; o_range_max <= '0;
                    o_last <= (r_mot + 1'b1 == {1'b0, nmot});
                    if (r_mot + 1'b1 == {1'b0, nmot}) r_state <= S_IDLE;
                    else r_mot <= r_mot + 1'b1;
                end
                S_DIVSET: begin
                    if (r_mot == {1'b0, nmot}) begin
                        r_state <= S_SATOUT;
                    end else if (cc == 0) begin
                        r_mot <= r_mot + 1'b1;
                    end else begin
                        r_neg <= (num < 0) != (cc < 0);
                        r_quo <= (num < 0) ? 40'(-num) : 40'(num);
                        r_den <= (cc < 0) ? 15'(-cc) : 15'(cc);
                        r_rem <= '0; r_dcnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!trial[40]) begin
                        r_rem <= trial; r_quo <= {r_quo[38:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[39:0], r_quo[39]}; r_quo <= {r_quo[38:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd39) r_state <= S_DIVEND;
                end
                S_DIVEND: begin
                    if (r_which == 1'b0) begin
                        if (qs < r_hi) r_hi <= qs;
                        r_which <= 1'b1;
                    end else begin
                        if (qs > r_lo) r_lo <= qs;
                        r_which <= 1'b0;
                        r_mot <= r_mot + 1'b1;
                    end
                    r_state <= S_DIVSET;
                end
                S_SATOUT: begin
                    o_valid <= 1'b1; o_status <= ST_OK; o_last <= 1'b1;
                    o_range_min <= r_lo; o_range_max <= r_hi;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `AST_IMPL(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `AST_IMPL(a_lvl_range, i_clk, i_rst_n, o_valid, o_motor_level <= OneLevel)
    `AST_IMPL(a_err_last, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_last)
    `AST_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_motor_level))
endmodule
`default_nettype wire
